@@ sv/segment_box_intersect_defines.svh @@
// assertion macros for the segment versus box test block
// used by the port checker; no other dependencies
`ifndef SEGMENT_BOX_INTERSECT_DEFINES_SVH
`define SEGMENT_BOX_INTERSECT_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define SBI_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define SBI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sbi_pkg.sv @@
// shared constants and types for the segment versus box test pipeline
// no dependencies
`default_nettype none

package sbi_pkg;

  // default coordinate width (two's complement, fraction bits do not matter)
  localparam int COORD_BITS_DEF = 40;

  // clock edges from an accepted item to its result strobe
  localparam int LATENCY = 5;

  localparam int NUM_AXES = 3;

  // ordered axis pairs (a, b) for the cross tests: entry of a before exit of b
  localparam int NUM_PAIRS = 6;
  localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 1, 1, 2, 2};
  localparam int PAIR_B [NUM_PAIRS] = '{1, 2, 2, 0, 0, 1};

  // per-axis status handed from the front end to the test stages
  typedef struct packed {
    logic zero_d;   // start and end share this coordinate
    logic between;  // start lies strictly between the two box faces
  } axis_flags_t;

endpackage

`default_nettype wire

@@ sv/sbi_axis_prep.sv @@
// front end for one axis: slab numerators and delta, sign-normalized and ordered
// depends on sbi_pkg
`default_nettype none

module sbi_axis_prep #(
  parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEF
) (
  input  wire                         clk,
  input  wire  signed [COORD_BITS-1:0] start_pos,
  input  wire  signed [COORD_BITS-1:0] end_pos,
  input  wire  signed [COORD_BITS-1:0] box_lo,
  input  wire  signed [COORD_BITS-1:0] box_hi,
  output logic        [COORD_BITS-1:0] d_mag,
  output logic signed [COORD_BITS:0]   num_near,
  output logic signed [COORD_BITS:0]   num_far,
  output sbi_pkg::axis_flags_t         flags
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] delta_r;
  logic signed [DW-1:0] n_lo_r;
  logic signed [DW-1:0] n_hi_r;

  logic signed [DW-1:0] delta_neg;
  logic signed [DW-1:0] m_lo;
  logic signed [DW-1:0] m_hi;
  logic                 flip;
  logic                 swap;

  logic        [COORD_BITS-1:0] d_mag_r, d_mag_nxt;
  logic signed [DW-1:0]         near_r, near_nxt;
  logic signed [DW-1:0]         far_r, far_nxt;
  sbi_pkg::axis_flags_t         flags_r, flags_nxt;

  // stage 1: delta and face offsets from the start point
  always_ff @(posedge clk) begin
    delta_r <= DW'(end_pos) - DW'(start_pos);
    n_lo_r  <= DW'(box_lo) - DW'(start_pos);
    n_hi_r  <= DW'(box_hi) - DW'(start_pos);
  end

  // stage 2: make the denominator positive, then order the two numerators
  always_comb begin
    flip      = delta_r[DW-1];
    delta_neg = -delta_r;
    m_lo      = flip ? -n_lo_r : n_lo_r;
    m_hi      = flip ? -n_hi_r : n_hi_r;
    swap      = m_lo > m_hi;
    d_mag_nxt = flip ? delta_neg[COORD_BITS-1:0] : delta_r[COORD_BITS-1:0];
    near_nxt  = swap ? m_hi : m_lo;
    far_nxt   = swap ? m_lo : m_hi;
    flags_nxt.zero_d = (delta_r == '0);
    // strictly inside: lower face below start, upper face above it
    flags_nxt.between = n_lo_r[DW-1] && !n_hi_r[DW-1] && (n_hi_r != '0);
  end

  always_ff @(posedge clk) begin
    d_mag_r <= d_mag_nxt;
    near_r  <= near_nxt;
    far_r   <= far_nxt;
    flags_r <= flags_nxt;
  end

  assign d_mag    = d_mag_r;
  assign num_near = near_r;
  assign num_far  = far_r;
  assign flags    = flags_r;

endmodule

`default_nettype wire

@@ sv/sbi_cross_mul.sv @@
// two-stage signed by unsigned multiplier for the exact parameter compares
// split into four narrow partial products, summed in the second stage; uses sbi_pkg
`default_nettype none

module sbi_cross_mul #(
  parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire  signed [COORD_BITS:0]   num,
  input  wire         [COORD_BITS-1:0] den,
  output logic signed [2*COORD_BITS:0] prod
);

  localparam int NW    = COORD_BITS + 1;
  localparam int SPLIT = NW / 2;
  localparam int NHW   = NW - SPLIT;
  localparam int DHW   = COORD_BITS - SPLIT;
  localparam int PW    = 2 * COORD_BITS + 1;

  logic        [SPLIT-1:0] num_lo;
  logic signed [NHW-1:0]   num_hi;
  logic        [SPLIT-1:0] den_lo;
  logic        [DHW-1:0]   den_hi;

  logic        [2*SPLIT-1:0]   pp_ll_r;
  logic        [SPLIT+DHW-1:0] pp_lh_r;
  logic signed [NHW+SPLIT:0]   pp_hl_r;
  logic signed [NHW+DHW:0]     pp_hh_r;

  logic [PW-1:0] ll_x;
  logic [PW-1:0] lh_x;
  logic [PW-1:0] hl_x;
  logic [PW-1:0] hh_x;
  logic [PW-1:0] prod_nxt;
  logic [PW-1:0] prod_r;

  assign num_lo = num[SPLIT-1:0];
  assign num_hi = num[NW-1:SPLIT];
  assign den_lo = den[SPLIT-1:0];
  assign den_hi = den[COORD_BITS-1:SPLIT];

  // stage a: partial products, low halves unsigned, top half of num signed
  always_ff @(posedge clk) begin
    pp_ll_r <= num_lo * den_lo;
    pp_lh_r <= num_lo * den_hi;
    pp_hl_r <= num_hi * $signed({1'b0, den_lo});
    pp_hh_r <= num_hi * $signed({1'b0, den_hi});
  end

  // stage b: align and add; the true product fits in PW bits
  always_comb begin
    ll_x     = PW'(pp_ll_r);
    lh_x     = PW'(pp_lh_r);
    hl_x     = PW'(pp_hl_r);
    hh_x     = PW'(pp_hh_r);
    prod_nxt = (hh_x << (2 * SPLIT)) + ((hl_x + lh_x) << SPLIT) + ll_x;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = $signed(prod_r);

endmodule

`default_nettype wire

@@ sv/segment_box_intersect.sv @@
// Segment versus axis-aligned box test, slab method, exact rational compares.
// One item is taken on every clock edge with start high; busy stays low, so
// the block never refuses an item. Each result shows on out_hit with out_valid
// high for exactly one cycle, once its item has passed the register stages
// listed below; results come in item order; the receiver cannot stall and
// the pipeline needs no backpressure.
// The five register stages are: face offsets and delta, sign normalization,
// partial products of the cross multiplies, product sum, final compare. The
// fraction bit count of the coordinates has no effect on the answer.
// Depends on sbi_pkg, sbi_axis_prep and sbi_cross_mul.
`default_nettype none

module segment_box_intersect #(
  parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  signed [COORD_BITS-1:0] in_start_x,
  input  wire  signed [COORD_BITS-1:0] in_start_y,
  input  wire  signed [COORD_BITS-1:0] in_start_z,
  input  wire  signed [COORD_BITS-1:0] in_end_x,
  input  wire  signed [COORD_BITS-1:0] in_end_y,
  input  wire  signed [COORD_BITS-1:0] in_end_z,
  input  wire  signed [COORD_BITS-1:0] in_box_min_x,
  input  wire  signed [COORD_BITS-1:0] in_box_min_y,
  input  wire  signed [COORD_BITS-1:0] in_box_min_z,
  input  wire  signed [COORD_BITS-1:0] in_box_max_x,
  input  wire  signed [COORD_BITS-1:0] in_box_max_y,
  input  wire  signed [COORD_BITS-1:0] in_box_max_z,
  output logic                        out_valid,
  output logic                        out_hit
);

  localparam int NA = sbi_pkg::NUM_AXES;
  localparam int NP = sbi_pkg::NUM_PAIRS;
  localparam int PW = 2 * COORD_BITS + 1;
  localparam int VW = sbi_pkg::LATENCY - 1;

  logic signed [COORD_BITS-1:0] start_pos [NA];
  logic signed [COORD_BITS-1:0] end_pos   [NA];
  logic signed [COORD_BITS-1:0] box_lo    [NA];
  logic signed [COORD_BITS-1:0] box_hi    [NA];

  logic        [COORD_BITS-1:0] d_mag    [NA];
  logic signed [COORD_BITS:0]   num_near [NA];
  logic signed [COORD_BITS:0]   num_far  [NA];
  sbi_pkg::axis_flags_t         flags    [NA];

  logic signed [PW-1:0] lhs_prod [NP];
  logic signed [PW-1:0] rhs_prod [NP];

  logic          accept;
  logic [VW-1:0] vld_r, vld_nxt;
  logic [NA-1:0] self3_nxt;
  logic [NA-1:0] self3_r, zd3_r;
  logic [NA-1:0] self4_r, zd4_r;
  logic [NP-1:0] pair_ok;
  logic          out_valid_r;
  logic          hit_r, hit_nxt;

  // every cycle is open for a new item
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign start_pos = '{in_start_x, in_start_y, in_start_z};
  assign end_pos   = '{in_end_x, in_end_y, in_end_z};
  assign box_lo    = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign box_hi    = '{in_box_max_x, in_box_max_y, in_box_max_z};

  // stages 1 and 2: per-axis front end
  for (genvar a = 0; a < NA; a++) begin : g_axis
    sbi_axis_prep #(.COORD_BITS(COORD_BITS)) u_prep (
      .clk      (clk),
      .start_pos(start_pos[a]),
      .end_pos  (end_pos[a]),
      .box_lo   (box_lo[a]),
      .box_hi   (box_hi[a]),
      .d_mag    (d_mag[a]),
      .num_near (num_near[a]),
      .num_far  (num_far[a]),
      .flags    (flags[a])
    );
  end

  // stages 3 and 4: cross products near_a * d_b and far_b * d_a
  for (genvar p = 0; p < NP; p++) begin : g_pair
    localparam int PA = sbi_pkg::PAIR_A[p];
    localparam int PB = sbi_pkg::PAIR_B[p];

    sbi_cross_mul #(.COORD_BITS(COORD_BITS)) u_mul_lhs (
      .clk (clk),
      .num (num_near[PA]),
      .den (d_mag[PB]),
      .prod(lhs_prod[p])
    );

    sbi_cross_mul #(.COORD_BITS(COORD_BITS)) u_mul_rhs (
      .clk (clk),
      .num (num_far[PB]),
      .den (d_mag[PA]),
      .prod(rhs_prod[p])
    );
  end

  // stage 3: tests within one axis (same denominator, or against 0 and 1)
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (flags[a].zero_d) begin
        self3_nxt[a] = flags[a].between;
      end else begin
        self3_nxt[a] = (num_near[a] < num_far[a]) &&
                       !num_far[a][COORD_BITS] && (num_far[a] != '0) &&
                       (num_near[a] < $signed({1'b0, d_mag[a]}));
      end
    end
  end

  // stage 3 and 4 flag registers, kept in step with the multipliers
  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      self3_r[a] <= self3_nxt[a];
      zd3_r[a]   <= flags[a].zero_d;
    end
    self4_r <= self3_r;
    zd4_r   <= zd3_r;
  end

  // stage 5: cross-axis compares; an axis with zero delta sets no bound
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      pair_ok[p] = zd4_r[sbi_pkg::PAIR_A[p]] || zd4_r[sbi_pkg::PAIR_B[p]] ||
                   (lhs_prod[p] < rhs_prod[p]);
    end
    hit_nxt = vld_r[VW-1] && (&self4_r) && (&pair_ok);
  end

  // valid bits travel beside the data
  assign vld_nxt = {vld_r[VW-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[VW-1];
      hit_r       <= hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = hit_r;

endmodule

`default_nettype wire

@@ sv/sbi_checker.sv @@
// port-level checker for segment_box_intersect, attached by bind
// depends on sbi_pkg and the assertion macros header
`include "segment_box_intersect_defines.svh"
`default_nettype none

module sbi_checker #(
  parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEF
) (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         start,
  input wire                         busy,
  input wire  signed [COORD_BITS-1:0] in_start_x,
  input wire  signed [COORD_BITS-1:0] in_end_x,
  input wire  signed [COORD_BITS-1:0] in_box_min_x,
  input wire  signed [COORD_BITS-1:0] in_box_max_x,
  input wire                         out_valid,
  input wire                         out_hit
);

  localparam int LAT = sbi_pkg::LATENCY;
  localparam int CW  = $clog2(LAT + 1);

  logic          accept;
  logic          x_below;
  logic [CW-1:0] clean_r, clean_nxt;

  assign accept = start && !busy;

  // whole segment at or below a proper box's lower x face cannot hit
  assign x_below = (in_start_x <= in_box_min_x) && (in_end_x <= in_box_min_x) &&
                   (in_box_min_x <= in_box_max_x);

  // edges since reset was released, saturating at the latency
  assign clean_nxt = (clean_r == CW'(LAT)) ? clean_r : clean_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clean_r <= '0;
    end else begin
      clean_r <= clean_nxt;
    end
  end

  // a hit flag only rides on a result strobe
  `SBI_ASSERT_IMPLIES(a_hit_needs_valid, clk, rst_n, out_hit, out_valid, "hit without valid")

  // every strobe goes back to an item taken exactly the latency earlier
  `SBI_ASSERT_IMPLIES(a_valid_has_item, clk, rst_n, out_valid, $past(accept, LAT), "stray result")

  // every item taken outside reset gets its strobe on time
  `SBI_ASSERT_NEXT(a_item_gets_result, clk, rst_n, (clean_r >= CW'(LAT - 1)) && $past(accept, LAT - 1), out_valid, "lost result")

  // a segment wholly below the box in x reports a miss
  `SBI_ASSERT_IMPLIES(a_below_misses, clk, rst_n, (clean_r == CW'(LAT)) && $past(accept && x_below, LAT), out_valid && !out_hit, "hit below box")

endmodule

bind segment_box_intersect sbi_checker #(.COORD_BITS(COORD_BITS)) u_sbi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_start_x  (in_start_x),
  .in_end_x    (in_end_x),
  .in_box_min_x(in_box_min_x),
  .in_box_max_x(in_box_max_x),
  .out_valid   (out_valid),
  .out_hit     (out_hit)
);

`default_nettype wire
